FILE: hw/rtl/lbu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbu_pkg
// Shared types and constants for the LSB-first bit unpacker.
// ----------------------------------------------------------------------------
package lbu_pkg;

  localparam int MAX_ATOMS = 65536;
  localparam int MAX_WIDTH = 32;

  localparam int COUNT_W = 17;
  localparam int WIDTH_W = 6;
  localparam int INDEX_W = 16;
  localparam int VALUE_W = 32;
  localparam int BYTE_W  = 8;
  localparam int ACC_W   = 40;
  localparam int HELD_W  = 6;
  localparam int NRES_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [COUNT_W-1:0] MAX_ATOMS_C = COUNT_W'(MAX_ATOMS);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_C = WIDTH_W'(MAX_WIDTH);
  localparam logic [NRES_W-1:0]  LAST_RESULT = NRES_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATOM_COUNT = 2'd0,
    REG_X_WIDTH    = 2'd1,
    REG_Y_WIDTH    = 2'd2,
    REG_Z_WIDTH    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } plane_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [WIDTH_W-1:0] x_width;
    logic [WIDTH_W-1:0] y_width;
    logic [WIDTH_W-1:0] z_width;
  } cfg_t;

endpackage

FILE: hw/rtl/lsb_first_bit_unpacker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_first_bit_unpacker_top
// Unpacks x, y, z planes of LSB-first packed values from a byte stream.
// ----------------------------------------------------------------------------
// One payload byte is accepted per transaction and merged into a bit
// accumulator; the block emits one value per cycle unless m_tready stalls,
// so a byte yielding k values (0..8, at most the values left in the plane)
// holds the single extraction stage until its last value, in whose cycle the
// next byte is taken. With widths of 8 or more this sustains one byte per
// cycle if not stalled. A byte yielding no value makes no output transaction.
// Each plane starts on a byte boundary; pad bits are dropped at plane end.
module lsb_first_bit_unpacker_top
  import lbu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // [31:0] coord_value, [47:32] atom_index
  output logic [2:0]            m_tuser,   // [1:0] axis, [2] frame_done
  output logic                  m_tlast    // last_of_byte
);

  cfg_t cfg;

  lbu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [ACC_W-1:0]   acc, acc_next;
  logic [HELD_W-1:0]  held, held_next;
  logic [INDEX_W-1:0] cnt, cnt_next;
  plane_t             plane, plane_next;
  logic [NRES_W-1:0]  nres, nres_next;
  logic               busy, busy_next;

  logic [ACC_W-1:0]   acc_base;
  logic [HELD_W-1:0]  held_base;
  logic [INDEX_W-1:0] cnt_base;
  plane_t             plane_base;

  logic [WIDTH_W-1:0] w, w_base;
  logic [VALUE_W-1:0] mask;
  logic               plane_end, last, emit, accept;
  logic [HELD_W-1:0]  held_sub;

  function automatic logic [WIDTH_W-1:0] width_of(input plane_t p, input cfg_t c);
    logic [WIDTH_W-1:0] r;
    case (p)
      AXIS_Y:  r = c.y_width;
      AXIS_Z:  r = c.z_width;
      default: r = c.x_width;
    endcase
    return r;
  endfunction

  assign w         = width_of(plane, cfg);
  assign mask      = ~({VALUE_W{1'b1}} << w);
  assign plane_end = ({1'b0, cnt} + COUNT_W'(1)) >= cfg.count;
  assign held_sub  = held - w;
  assign last      = plane_end || (nres == LAST_RESULT) || (held_sub < w);
  assign emit      = busy && (!m_tvalid || m_tready);
  assign s_tready  = !busy || (emit && last);
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    acc_base   = acc;
    held_base  = held;
    cnt_base   = cnt;
    plane_base = plane;
    if (emit) begin
      if (plane_end) begin
        acc_base  = '0;
        held_base = '0;
        cnt_base  = '0;
        case (plane)
          AXIS_X:  plane_base = AXIS_Y;
          AXIS_Y:  plane_base = AXIS_Z;
          default: plane_base = AXIS_X;
        endcase
      end else begin
        acc_base  = acc >> w;
        held_base = held_sub;
        cnt_base  = cnt + INDEX_W'(1);
      end
    end
  end

  assign w_base = width_of(plane_base, cfg);

  always_comb begin
    acc_next   = acc_base;
    held_next  = held_base;
    cnt_next   = cnt_base;
    plane_next = plane_base;
    nres_next  = nres;
    busy_next  = busy;
    if (accept) begin
      acc_next  = acc_base | (ACC_W'(s_tdata) << held_base);
      held_next = held_base + HELD_W'(BYTE_W);
      nres_next = '0;
      busy_next = (held_base + HELD_W'(BYTE_W)) >= w_base;
    end else if (emit) begin
      nres_next = nres + NRES_W'(1);
      busy_next = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      held  <= '0;
      cnt   <= '0;
      plane <= AXIS_X;
      nres  <= '0;
      busy  <= 1'b0;
    end else begin
      acc   <= acc_next;
      held  <= held_next;
      cnt   <= cnt_next;
      plane <= plane_next;
      nres  <= nres_next;
      busy  <= busy_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {cnt, acc[VALUE_W-1:0] & mask};
      m_tuser <= {plane_end && (plane == AXIS_Z), plane};
      m_tlast <= last;
    end
  end

`ifndef SYNTHESIS
  a_busy_has_bits: assert property (@(posedge clk) disable iff (rst)
    busy |-> (held >= w))
    else $error("extraction pending without enough bits");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= HELD_W'(39))
    else $error("bit accumulator overfilled");

  a_done_on_z: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == AXIS_Z))
    else $error("frame done outside z plane");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> m_tlast)
    else $error("frame done without last of byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !busy))
    else $error("not idle after reset");
`endif

endmodule

FILE: hw/rtl/lbu_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbu_cfg_regs
// Configuration registers with range clamping of count and widths.
// ----------------------------------------------------------------------------
module lbu_cfg_regs
  import lbu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [COUNT_W-1:0] atom_count;
  logic [WIDTH_W-1:0] x_width;
  logic [WIDTH_W-1:0] y_width;
  logic [WIDTH_W-1:0] z_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      atom_count <= COUNT_W'(1);
      x_width    <= WIDTH_W'(8);
      y_width    <= WIDTH_W'(8);
      z_width    <= WIDTH_W'(8);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ATOM_COUNT: atom_count <= cfg_data[COUNT_W-1:0];
        REG_X_WIDTH:    x_width    <= cfg_data[WIDTH_W-1:0];
        REG_Y_WIDTH:    y_width    <= cfg_data[WIDTH_W-1:0];
        REG_Z_WIDTH:    z_width    <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] r;
    r = w;
    if (w == '0) r = WIDTH_W'(1);
    else if (w > MAX_WIDTH_C) r = MAX_WIDTH_C;
    return r;
  endfunction

  always_comb begin
    cfg.x_width = clamp_width(x_width);
    cfg.y_width = clamp_width(y_width);
    cfg.z_width = clamp_width(z_width);
    if (atom_count == '0) cfg.count = COUNT_W'(1);
    else if (atom_count > MAX_ATOMS_C) cfg.count = MAX_ATOMS_C;
    else cfg.count = atom_count;
  end

endmodule
